// ----- rtl/core/lkvc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, codes, defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package lkvc_pkg;

  // Payload widths fixed by the item format.
  localparam int KEY_W  = 32;
  localparam int VAL_W  = 32;
  localparam int CAP_W  = 5;
  localparam int MODE_W = 1;

  // Default table depth.
  localparam int DEFAULT_MAX_ENTRIES = 16;

  // Capacity register value after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Operation codes carried in tuser.
  localparam logic [MODE_W-1:0] MODE_LOOKUP = 1'b0;
  localparam logic [MODE_W-1:0] MODE_STORE  = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_FINISH
  } lkvc_state_t;

endpackage

// ----- rtl/core/lkvc_ram.sv -----
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/lru_key_value_cache_top.sv -----
// ----------------------------------------------------------------------------
// LRU key-value cache, fully associative
// Holds up to MAX_ENTRIES key/value pairs with least-recently-used replacement.
//
// Usage:
//   The input stream carries one lookup or store per beat: tuser is the mode
//   (0 lookup, 1 store), tdata holds the key in bits 31:0 and the value in
//   bits 63:32. A lookup gives one output beat: tuser is the hit flag and
//   tdata the stored value, or zero on a miss. A store gives no output beat.
//   The cfg channel writes the capacity (entries in use before eviction).
//   Every beat is handled by one sequencer that sweeps the entry memories one
//   entry per cycle: a compare sweep finds the key, the oldest entry and a
//   free slot, then a rank sweep (skipped on a lookup miss) ages the entries
//   younger than the target, or all of them when a free slot is filled.
//   The lookup result is loaded into the output register in the finish state.
//   The input is not ready while an item is being worked on. Reset empties the
//   table and sets the capacity to 16. A stalled output beat holds; the next
//   item can be accepted meanwhile, and a second lookup result waits in the
//   finish state until the output register is free.
// ----------------------------------------------------------------------------
module lru_key_value_cache_top #(
  parameter int MAX_ENTRIES = lkvc_pkg::DEFAULT_MAX_ENTRIES
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // Input beat: tdata fields from bit 0 up: key, value.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0] s_axis_tdata,
  // tuser = mode.
  input  logic [lkvc_pkg::MODE_W-1:0]            s_axis_tuser,
  // Output beat: tdata = read_value.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [lkvc_pkg::VAL_W-1:0]             m_axis_tdata,
  // tuser = hit.
  output logic                                   m_axis_tuser,
  // Capacity write channel.
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]             cfg_data
);

  import lkvc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int RANK_W = IDX_W;
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // Sequencer and control state.
  lkvc_state_t state, state_next;
  logic [CNT_W-1:0]       cnt;
  logic                   chk_vld;
  logic [IDX_W-1:0]       chk_idx;
  logic [MAX_ENTRIES-1:0] entry_valid;
  logic [CNT_W-1:0]       entry_count;
  logic [CAP_W-1:0]       capacity;

  // Latched item.
  logic [MODE_W-1:0] mode_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  value_q;

  // Scan results.
  logic              found;
  logic [IDX_W-1:0]  hit_idx;
  logic [RANK_W-1:0] hit_rank;
  logic [VAL_W-1:0]  hit_val;
  logic              lru_found;
  logic [IDX_W-1:0]  lru_idx;
  logic [RANK_W-1:0] lru_rank;
  logic              free_found;
  logic [IDX_W-1:0]  free_idx;

  // Decision for the rank sweep and the final write.
  logic              do_update;
  logic [IDX_W-1:0]  tgt_idx;
  logic [RANK_W-1:0] thr_rank;
  logic              age_all;
  logic              new_entry;

  // Memory ports.
  logic [KEY_W-1:0]  key_rd;
  logic [VAL_W-1:0]  val_rd;
  logic [RANK_W-1:0] rank_rd;
  logic              kv_we;
  logic              rank_we;
  logic [RANK_W-1:0] rank_wdata;
  logic [IDX_W-1:0]  rd_addr;

  // Combinational helpers.
  logic             issue;
  logic             sweep_end;
  logic             chk_valid;
  logic             key_match;
  logic [CMP_W-1:0] eff_cap;
  logic             table_full;
  logic             finish_go;

  assign cfg_ready = 1'b1;
  assign rd_addr   = cnt[IDX_W-1:0];
  assign issue     = cnt < CNT_W'(MAX_ENTRIES);
  assign sweep_end = cnt == CNT_W'(MAX_ENTRIES);
  assign chk_valid = entry_valid[chk_idx];
  assign key_match = chk_valid && (key_rd == key_q);

  // Capacity clamped to 1..MAX_ENTRIES.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(MAX_ENTRIES)) begin
      eff_cap = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end
  assign table_full = CMP_W'(entry_count) >= eff_cap;

  // Entry memories.
  lkvc_ram #(.WIDTH(KEY_W), .DEPTH(MAX_ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (tgt_idx),
    .wdata (key_q),
    .raddr (rd_addr),
    .rdata (key_rd)
  );

  lkvc_ram #(.WIDTH(VAL_W), .DEPTH(MAX_ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (kv_we),
    .waddr (tgt_idx),
    .wdata (value_q),
    .raddr (rd_addr),
    .rdata (val_rd)
  );

  lkvc_ram #(.WIDTH(RANK_W), .DEPTH(MAX_ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (chk_idx),
    .wdata (rank_wdata),
    .raddr (rd_addr),
    .rdata (rank_rd)
  );

  // New rank of the entry coming out of the memory during the rank sweep.
  always_comb begin
    if (chk_idx == tgt_idx) begin
      rank_wdata = '0;
    end else if (age_all || (rank_rd < thr_rank)) begin
      rank_wdata = rank_rd + RANK_W'(1);
    end else begin
      rank_wdata = rank_rd;
    end
  end

  // Next state and sequencer outputs.
  always_comb begin
    state_next    = state;
    s_axis_tready = 1'b0;
    rank_we       = 1'b0;
    kv_we         = 1'b0;
    finish_go     = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sweep_end) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (mode_q == MODE_LOOKUP && !found) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        rank_we = chk_vld && (chk_valid || chk_idx == tgt_idx);
        if (sweep_end) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish_go = (mode_q == MODE_STORE) || !m_axis_tvalid || m_axis_tready;
        kv_we     = mode_q == MODE_STORE;
        if (finish_go) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sweep counter and the pipelined read address.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      chk_vld <= 1'b0;
    end else begin
      if (state == ST_IDLE || state == ST_DECIDE) begin
        cnt     <= '0;
        chk_vld <= 1'b0;
      end else if ((state == ST_SCAN || state == ST_UPDATE) && issue) begin
        cnt     <= cnt + CNT_W'(1);
        chk_vld <= 1'b1;
      end else begin
        chk_vld <= 1'b0;
      end
    end
    chk_idx <= rd_addr;
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Item latch.
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      mode_q  <= s_axis_tuser;
      key_q   <= s_axis_tdata[KEY_W-1:0];
      value_q <= s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
    end
  end

  // Compare sweep: first matching key, oldest valid entry, first free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      found      <= 1'b0;
      lru_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_IDLE) begin
      found      <= 1'b0;
      lru_found  <= 1'b0;
      free_found <= 1'b0;
    end else if (state == ST_SCAN && chk_vld) begin
      if (key_match && !found) begin
        found    <= 1'b1;
        hit_idx  <= chk_idx;
        hit_rank <= rank_rd;
        hit_val  <= val_rd;
      end
      if (chk_valid && (!lru_found || rank_rd > lru_rank)) begin
        lru_found <= 1'b1;
        lru_idx   <= chk_idx;
        lru_rank  <= rank_rd;
      end
      if (!chk_valid && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= chk_idx;
      end
    end
  end

  // Pick the entry to promote, replace or fill.
  always_ff @(posedge clk) begin
    if (rst) begin
      do_update <= 1'b0;
      age_all   <= 1'b0;
      new_entry <= 1'b0;
    end else if (state == ST_DECIDE) begin
      do_update <= found || mode_q == MODE_STORE;
      if (found) begin
        tgt_idx   <= hit_idx;
        thr_rank  <= hit_rank;
        age_all   <= 1'b0;
        new_entry <= 1'b0;
      end else if (table_full) begin
        tgt_idx   <= lru_idx;
        thr_rank  <= lru_rank;
        age_all   <= 1'b0;
        new_entry <= 1'b0;
      end else begin
        tgt_idx   <= free_idx;
        thr_rank  <= '0;
        age_all   <= 1'b1;
        new_entry <= mode_q == MODE_STORE;
      end
    end
  end

  // Valid bits and entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      entry_count <= '0;
    end else if (state == ST_FINISH && finish_go && new_entry) begin
      entry_valid[tgt_idx] <= 1'b1;
      entry_count          <= entry_count + CNT_W'(1);
    end
  end

  // Output register: loaded by a finished lookup, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (state == ST_FINISH && finish_go && mode_q == MODE_LOOKUP) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && finish_go && mode_q == MODE_LOOKUP) begin
      m_axis_tuser <= found;
      m_axis_tdata <= found ? hit_val : '0;
    end
  end

  // The count always matches the number of valid entries.
  a_count_matches_valid: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == 32'(entry_count))
    else $error("entry count differs from valid bits");

  // A store of a new key into a table that is not full always finds a free slot.
  a_free_slot_exists: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && mode_q == MODE_STORE && !found && !table_full) |=> new_entry)
    else $error("no free slot for a new entry");

  // A full table always has an oldest entry to evict.
  a_lru_exists: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DECIDE && !found && table_full) |-> lru_found)
    else $error("table full but no oldest entry found");

  // A new output beat only follows a finished lookup.
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_FINISH && mode_q == MODE_LOOKUP))
    else $error("output beat without a lookup");

  // A lookup miss skips the rank sweep.
  a_miss_no_update: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> do_update)
    else $error("rank sweep without a target");

endmodule
